// ----- sv/mac_pkg.sv -----
`timescale 1ns / 1ps

package mac_pkg;

  localparam int CASH_W    = 48;
  localparam int IDX_W     = 16;
  localparam int PERIOD_W  = 9;
  localparam int PRICE_W   = 24;
  localparam int PROFIT_W  = 49;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = $clog2(CASH_W);

  localparam int DEF_MAX_PERIOD = 256;
  localparam int DEF_PRICE_BITS = 24;

  localparam logic [PERIOD_W-1:0] RST_PERIOD_A = 9'd5;
  localparam logic [PERIOD_W-1:0] RST_PERIOD_B = 9'd20;
  localparam logic [IDX_W-1:0]    RST_START    = 16'd19;
  localparam logic [CASH_W-1:0]   RST_CASH     = 48'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CASH     = 3'd3;

  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SELL  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FINAL = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUM,
    OP_CMP,
    OP_EVAL,
    OP_DIV,
    OP_BUY,
    OP_MLO,
    OP_MHI,
    OP_SELL,
    OP_LIQ,
    OP_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic buy;
    logic sell;
    logic need_liq;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- sv/mac_datapath.sv -----
`timescale 1ns / 1ps

module mac_datapath #(
  parameter int MAX_PERIOD = mac_pkg::DEF_MAX_PERIOD,
  parameter int PRICE_BITS = mac_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mac_pkg::CASH_W-1:0]          cfg_data_i,
  input  logic [mac_pkg::PRICE_W-1:0]         price_i,
  input  logic                                last_i,
  input  mac_pkg::dp_cmd_t                    cmd_i,
  output mac_pkg::dp_stat_t                   stat_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic [mac_pkg::ACT_W-1:0]           action_o,
  output logic [mac_pkg::CASH_W-1:0]          shares_held_o,
  output logic [mac_pkg::CASH_W-1:0]          cash_o,
  output logic signed [mac_pkg::PROFIT_W-1:0] profit_o,
  output logic                                stopped_o
);
  import mac_pkg::*;

  localparam int AW      = $clog2(MAX_PERIOD);
  localparam int PER_W   = $clog2(MAX_PERIOD + 1);
  localparam int SUM_W   = PRICE_BITS + PER_W;
  localparam int PROD_W  = SUM_W + PER_W;
  localparam int CHUNK_W = CASH_W / 2;
  localparam int MP_W    = CHUNK_W + PRICE_BITS;
  localparam int ACC_W   = CASH_W + PRICE_BITS;
  localparam int REM_W   = PRICE_BITS + 1;
  localparam logic [AW-1:0]     LAST_POS = AW'(MAX_PERIOD - 1);
  localparam logic [CASH_W-1:0] CASH_MAX = '1;
  localparam logic [IDX_W-1:0]  IDX_MAX  = '1;

  function automatic logic [PER_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
    logic [31:0] v;
    v = 32'(p);
    if (v == 32'd0) begin
      v = 32'd1;
    end else if (v > 32'(MAX_PERIOD)) begin
      v = 32'(MAX_PERIOD);
    end
    return v[PER_W-1:0];
  endfunction

  logic [PERIOD_W-1:0]   per_a_q, per_b_q;
  logic [IDX_W-1:0]      start_q;
  logic [CASH_W-1:0]     init_cash_q;

  logic [PRICE_BITS-1:0] mem_q [MAX_PERIOD];
  logic [PRICE_BITS-1:0] rdata_q;
  logic                  rvld_q;
  logic [MAX_PERIOD-1:0] vld_q;
  logic [AW-1:0]         wr_q, rd_q;
  logic [PER_W-1:0]      iss_q;
  logic                  pend_q, pend_s_q;

  logic [PRICE_BITS-1:0] price_q;
  logic                  last_q;
  logic [SUM_W-1:0]      sum_s_q, sum_l_q, prev_s_q, prev_l_q;
  logic [PROD_W-1:0]     prod_q [4];
  logic                  halted_q, inv_q;
  logic [CASH_W-1:0]     share_q, cash_q, quo_q;
  logic [PRICE_BITS-1:0] rem_q;
  logic [ACC_W-1:0]      macc_q;
  logic [IDX_W-1:0]      idx_q;
  logic [ACT_W-1:0]      action_q;

  logic                  out_valid_q, stopped_q;
  logic [ACT_W-1:0]      out_action_q;
  logic [CASH_W-1:0]     out_shares_q, out_cash_q;
  logic [PROFIT_W-1:0]   out_profit_q;

  logic [PER_W-1:0]      pa, pb, ps, pl;
  logic [31:0]           price_ext;
  logic [PRICE_BITS-1:0] price_in;
  logic [SUM_W-1:0]      rd_val;
  logic [SUM_W-1:0]      mul_a;
  logic [PER_W-1:0]      mul_b;
  logic [PROD_W-1:0]     cmp_prod;
  logic                  ev, early, cond_buy, cond_sell;
  logic [REM_W-1:0]      rem_sh;
  logic                  rem_ge;
  logic [REM_W-1:0]      rem_sub;
  logic [CHUNK_W-1:0]    mchunk;
  logic [MP_W-1:0]       mprod;
  logic [ACC_W:0]        sale;
  logic [CASH_W-1:0]     sale_sat;
  logic [AW-1:0]         wr_next, rd_next;

  always_comb begin
    pa = clamp_period(per_a_q);
    pb = clamp_period(per_b_q);
    ps = (pa > pb) ? pb : pa;
    pl = (pa > pb) ? pa : pb;

    price_ext = 32'(price_i);
    price_in  = price_ext[PRICE_BITS-1:0];

    wr_next = (wr_q == LAST_POS) ? '0 : wr_q + AW'(1);
    rd_next = (rd_q == '0) ? LAST_POS : rd_q - AW'(1);
    rd_val  = rvld_q ? SUM_W'(rdata_q) : '0;

    case (cmd_i.sel)
      2'd0:    mul_a = sum_s_q;
      2'd1:    mul_a = sum_l_q;
      2'd2:    mul_a = prev_s_q;
      default: mul_a = prev_l_q;
    endcase
    mul_b    = cmd_i.sel[0] ? ps : pl;
    cmp_prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    ev        = !halted_q && (idx_q >= start_q);
    early     = (32'(idx_q) + 32'd1) < 32'(pl);
    cond_buy  = ev && !early && !inv_q && (prod_q[2] <= prod_q[3]) &&
                (prod_q[0] > prod_q[1]) && (prev_s_q != '0);
    cond_sell = ev && !early && inv_q && (prod_q[2] >= prod_q[3]) &&
                (prod_q[0] < prod_q[1]);

    rem_sh  = {rem_q, quo_q[CASH_W-1]};
    rem_ge  = rem_sh >= {1'b0, price_q};
    rem_sub = rem_ge ? (rem_sh - {1'b0, price_q}) : rem_sh;

    mchunk   = (cmd_i.op == OP_MHI) ? share_q[CASH_W-1:CHUNK_W] : share_q[CHUNK_W-1:0];
    mprod    = MP_W'(mchunk) * MP_W'(price_q);
    sale     = {1'b0, macc_q} + (ACC_W + 1)'(cash_q);
    sale_sat = (sale > (ACC_W + 1)'(CASH_MAX)) ? CASH_MAX : sale[CASH_W-1:0];

    stat_o.sum_done = (iss_q == pl) && !pend_q;
    stat_o.buy      = cond_buy;
    stat_o.sell     = cond_sell;
    stat_o.need_liq = last_q && inv_q && (share_q != '0);
    stat_o.out_free = !out_valid_q || !out_stall_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      mem_q[wr_q] <= price_in;
    end
    rdata_q <= mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_a_q      <= RST_PERIOD_A;
      per_b_q      <= RST_PERIOD_B;
      start_q      <= RST_START;
      init_cash_q  <= RST_CASH;
      rvld_q       <= 1'b0;
      vld_q        <= '0;
      wr_q         <= '0;
      rd_q         <= '0;
      iss_q        <= '0;
      pend_q       <= 1'b0;
      pend_s_q     <= 1'b0;
      price_q      <= '0;
      last_q       <= 1'b0;
      sum_s_q      <= '0;
      sum_l_q      <= '0;
      prev_s_q     <= '0;
      prev_l_q     <= '0;
      prod_q       <= '{default: '0};
      halted_q     <= 1'b0;
      inv_q        <= 1'b0;
      share_q      <= '0;
      cash_q       <= RST_CASH;
      quo_q        <= '0;
      rem_q        <= '0;
      macc_q       <= '0;
      idx_q        <= '0;
      action_q     <= ACT_NONE;
      out_valid_q  <= 1'b0;
      stopped_q    <= 1'b0;
      out_action_q <= ACT_NONE;
      out_shares_q <= '0;
      out_cash_q   <= '0;
      out_profit_q <= '0;
    end else begin
      rvld_q <= vld_q[rd_q];

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PERIOD_A: per_a_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_PERIOD_B: per_b_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_START:    start_q <= cfg_data_i[IDX_W-1:0];
          CFG_CASH: begin
            init_cash_q <= cfg_data_i;
            if (idx_q == '0) begin
              cash_q <= cfg_data_i;
            end
          end
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (cmd_i.op != OP_FIN)) begin
        out_valid_q <= 1'b0;
      end

      unique case (cmd_i.op)
        OP_LOAD: begin
          price_q     <= price_in;
          last_q      <= last_i;
          action_q    <= ACT_NONE;
          vld_q[wr_q] <= 1'b1;
          wr_q        <= wr_next;
          rd_q        <= wr_q;
          iss_q       <= '0;
          pend_q      <= 1'b0;
          sum_s_q     <= '0;
          sum_l_q     <= '0;
        end
        OP_SUM: begin
          if (iss_q < pl) begin
            rd_q     <= rd_next;
            iss_q    <= iss_q + PER_W'(1);
            pend_q   <= 1'b1;
            pend_s_q <= iss_q < ps;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q) begin
            sum_l_q <= sum_l_q + rd_val;
            if (pend_s_q) begin
              sum_s_q <= sum_s_q + rd_val;
            end
          end
        end
        OP_CMP: prod_q[cmd_i.sel] <= cmp_prod;
        OP_EVAL: begin
          if (ev && early) begin
            halted_q <= 1'b1;
          end else if (ev) begin
            prev_s_q <= sum_s_q;
            prev_l_q <= sum_l_q;
          end
          quo_q <= cash_q;
          rem_q <= '0;
        end
        OP_DIV: begin
          rem_q <= rem_sub[PRICE_BITS-1:0];
          quo_q <= {quo_q[CASH_W-2:0], rem_ge};
        end
        OP_BUY: begin
          if (price_q != '0) begin
            share_q <= quo_q;
            cash_q  <= CASH_W'(rem_q);
          end
          inv_q    <= 1'b1;
          action_q <= ACT_BUY;
        end
        OP_MLO: macc_q <= ACC_W'(mprod);
        OP_MHI: macc_q <= macc_q + (ACC_W'(mprod) << CHUNK_W);
        OP_SELL: begin
          cash_q   <= sale_sat;
          share_q  <= '0;
          inv_q    <= 1'b0;
          action_q <= ACT_SELL;
        end
        OP_LIQ: begin
          cash_q  <= sale_sat;
          share_q <= '0;
          inv_q   <= 1'b0;
        end
        OP_FIN: begin
          out_valid_q  <= 1'b1;
          out_action_q <= last_q ? ACT_FINAL : action_q;
          out_shares_q <= share_q;
          out_cash_q   <= cash_q;
          out_profit_q <= last_q ? ({1'b0, cash_q} - {1'b0, init_cash_q}) : '0;
          stopped_q    <= halted_q;
          if (last_q) begin
            vld_q    <= '0;
            wr_q     <= '0;
            sum_s_q  <= '0;
            sum_l_q  <= '0;
            prev_s_q <= '0;
            prev_l_q <= '0;
            halted_q <= 1'b0;
            inv_q    <= 1'b0;
            share_q  <= '0;
            cash_q   <= init_cash_q;
            idx_q    <= '0;
          end else if (idx_q != IDX_MAX) begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_action_q;
  assign shares_held_o = out_shares_q;
  assign cash_o        = out_cash_q;
  assign profit_o      = $signed(out_profit_q);
  assign stopped_o     = stopped_q;

  a_shares_need_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    share_q != '0 |-> inv_q)
    else $error("shares held while flat");

  a_long_covers_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SUM) && stat_o.sum_done |-> sum_l_q >= sum_s_q)
    else $error("long window sum below short window sum");

  a_buy_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_BUY) && (price_q != '0) |-> rem_q < price_q)
    else $error("division remainder not below price");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(halted_q) |-> $past(cmd_i.op == OP_FIN && last_q))
    else $error("halt released before the final item");

endmodule

// ----- sv/mac_ctrl.sv -----
`timescale 1ns / 1ps

module mac_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mac_pkg::dp_stat_t stat_i,
  output mac_pkg::dp_cmd_t  cmd_o
);
  import mac_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_CMP,
    S_EVAL,
    S_DIV,
    S_BUY,
    S_CHK,
    S_MLO,
    S_MHI,
    S_COMMIT,
    S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             sell_q;

  always_comb begin
    cmd_o.op  = OP_NONE;
    cmd_o.sel = cnt_q[1:0];
    unique case (state_q)
      S_IDLE:   cmd_o.op = in_valid_i ? OP_LOAD : OP_NONE;
      S_SUM:    cmd_o.op = OP_SUM;
      S_CMP:    cmd_o.op = OP_CMP;
      S_EVAL:   cmd_o.op = OP_EVAL;
      S_DIV:    cmd_o.op = OP_DIV;
      S_BUY:    cmd_o.op = OP_BUY;
      S_CHK:    cmd_o.op = OP_NONE;
      S_MLO:    cmd_o.op = OP_MLO;
      S_MHI:    cmd_o.op = OP_MHI;
      S_COMMIT: cmd_o.op = sell_q ? OP_SELL : OP_LIQ;
      S_FIN:    cmd_o.op = stat_i.out_free ? OP_FIN : OP_NONE;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      sell_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (stat_i.sum_done) begin
            state_q <= S_CMP;
            cnt_q   <= '0;
          end
        end
        S_CMP: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(3)) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          cnt_q <= '0;
          if (stat_i.buy) begin
            state_q <= S_DIV;
          end else if (stat_i.sell) begin
            state_q <= S_MLO;
            sell_q  <= 1'b1;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(CASH_W - 1)) begin
            state_q <= S_BUY;
          end
        end
        S_BUY: state_q <= S_CHK;
        S_CHK: begin
          if (stat_i.need_liq) begin
            state_q <= S_MLO;
            sell_q  <= 1'b0;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_MLO:    state_q <= S_MHI;
        S_MHI:    state_q <= S_COMMIT;
        S_COMMIT: state_q <= S_CHK;
        S_FIN: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/moving_average_crossover_trader.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   price_i, last_i
// out       source     out_valid_o / out_stall_i action_o, shares_held_o, cash_o,
//                                                profit_o, stopped_o
// cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
// One request is processed at a time. The window sums are rebuilt with one price
// memory read per cycle over the long window. A buy runs a bit-serial share division;
// a sale and the final liquidation run a two-part cash multiplication.
// Reset clears the price history valid bits at once; no clearing pass is needed.
// A stalled output holds its result; a request in progress waits for it only at the output step.

module moving_average_crossover_trader #(
  parameter int MAX_PERIOD = mac_pkg::DEF_MAX_PERIOD,
  parameter int PRICE_BITS = mac_pkg::DEF_PRICE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mac_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mac_pkg::CASH_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mac_pkg::PRICE_W-1:0]         price_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mac_pkg::ACT_W-1:0]           action_o,
  output logic [mac_pkg::CASH_W-1:0]          shares_held_o,
  output logic [mac_pkg::CASH_W-1:0]          cash_o,
  output logic signed [mac_pkg::PROFIT_W-1:0] profit_o,
  output logic                                stopped_o
);
  import mac_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mac_datapath #(
    .MAX_PERIOD (MAX_PERIOD),
    .PRICE_BITS (PRICE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .price_i       (price_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .action_o      (action_o),
    .shares_held_o (shares_held_o),
    .cash_o        (cash_o),
    .profit_o      (profit_o),
    .stopped_o     (stopped_o)
  );

endmodule
